// File: src/dess_pkg.sv
// Package for the de-esser sample processor: widths, register indexes,
// step codes, controller/datapath structs and the log2 and tanh tables.
// No dependencies.
package dess_pkg;

  localparam int NUM_CHANNELS     = 2;
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int LOG_TABLE_DEPTH  = 64;
  localparam int TanhW            = $clog2(TANH_TABLE_DEPTH);
  localparam int LogW             = $clog2(LOG_TABLE_DEPTH);

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int THR_W      = 16;
  localparam int AMT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int BAND_W     = 32;
  localparam int ENV_W      = 24;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int DB_W       = 18;
  localparam int L2_W       = 23;
  localparam int STEP_W     = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAND_B0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_A1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_A2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT     = 3'd6;

  // sequencer steps, also the controller state codes
  localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] ST_B0X  = 5'd1;
  localparam logic [STEP_W-1:0] ST_B0D  = 5'd2;
  localparam logic [STEP_W-1:0] ST_A1   = 5'd3;
  localparam logic [STEP_W-1:0] ST_A2   = 5'd4;
  localparam logic [STEP_W-1:0] ST_Y    = 5'd5;
  localparam logic [STEP_W-1:0] ST_M    = 5'd6;
  localparam logic [STEP_W-1:0] ST_ENV  = 5'd7;
  localparam logic [STEP_W-1:0] ST_ENVW = 5'd8;
  localparam logic [STEP_W-1:0] ST_LOG  = 5'd9;
  localparam logic [STEP_W-1:0] ST_DB   = 5'd10;
  localparam logic [STEP_W-1:0] ST_CMP  = 5'd11;
  localparam logic [STEP_W-1:0] ST_OVER = 5'd12;
  localparam logic [STEP_W-1:0] ST_TI   = 5'd13;
  localparam logic [STEP_W-1:0] ST_RED  = 5'd14;
  localparam logic [STEP_W-1:0] ST_RCL  = 5'd15;
  localparam logic [STEP_W-1:0] ST_RY   = 5'd16;
  localparam logic [STEP_W-1:0] ST_FIN  = 5'd17;

  localparam logic signed [DB_W-1:0] ZERO_LEVEL_DB   = -18'sd46080;
  localparam logic [16:0]            ONE_Q16         = 17'd65536;
  localparam int                     DB_PER_LOG2_Q16 = 394566;
  localparam int                     SCALE_012_Q16   = 7864;

  typedef struct packed {
    logic              capture;
    logic              load_out;
    logic [STEP_W-1:0] step;
  } dess_cmd_t;

  typedef struct packed {
    logic chan_ok;
  } dess_status_t;

  typedef logic [15:0] log_tab_t  [LOG_TABLE_DEPTH];
  typedef logic [16:0] tanh_tab_t [TANH_TABLE_DEPTH];

  // shift-and-subtract quotient, only used while building the tables
  function automatic longint unsigned table_div(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // log2(1 + i/D) in Q16 by repeated squaring
  function automatic log_tab_t gen_log_tab();
    log_tab_t          tab;
    longint unsigned   x;
    longint unsigned   r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = (longint'(LOG_TABLE_DEPTH + i) << 30) >> LogW;
      r = 0;
      for (int k = 0; k < 20; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r = r | 64'd1;
          x = x >> 1;
        end
      end
      tab[i] = 16'((r + 64'd8) >> 4);
    end
    return tab;
  endfunction

  // tanh(8i/D) in Q16: series on a small argument, then doubling
  function automatic tanh_tab_t gen_tanh_tab();
    tanh_tab_t         tab;
    longint unsigned   z;
    longint unsigned   z2;
    longint unsigned   z3;
    longint unsigned   z5;
    longint unsigned   t;
    for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
      z  = (longint'(i) << 23) >> TanhW;
      z2 = (z * z) >> 30;
      z3 = (z2 * z) >> 30;
      z5 = (z3 * z2) >> 30;
      t  = z - table_div(z3, 64'd3) + table_div(2 * z5, 64'd15);
      for (int k = 0; k < 10; k++) begin
        t = table_div((2 * t) << 30, (64'd1 << 30) + ((t * t) >> 30));
      end
      tab[i] = 17'((t + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam log_tab_t  LOG_TAB  = gen_log_tab();
  localparam tanh_tab_t TANH_TAB = gen_tanh_tab();

endpackage

// File: src/dess_ctrl.sv
// Sequencer for the de-esser: walks one sample through the shared
// multiplier steps and owns both handshakes. Uses dess_pkg.
module dess_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  input  dess_pkg::dess_status_t  status,
  output dess_pkg::dess_cmd_t     cmd
);
  import dess_pkg::*;

  logic [STEP_W-1:0] state;
  logic [STEP_W-1:0] state_next;
  logic              out_valid;
  logic              out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.step     = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_B0X;
        end
      end
      // out-of-range channel: skip the filter and pass the sample on
      ST_B0X:  state_next = status.chan_ok ? ST_B0D : ST_FIN;
      ST_B0D:  state_next = ST_A1;
      ST_A1:   state_next = ST_A2;
      ST_A2:   state_next = ST_Y;
      ST_Y:    state_next = ST_M;
      ST_M:    state_next = ST_ENV;
      ST_ENV:  state_next = ST_ENVW;
      ST_ENVW: state_next = ST_LOG;
      ST_LOG:  state_next = ST_DB;
      ST_DB:   state_next = ST_CMP;
      ST_CMP:  state_next = ST_OVER;
      ST_OVER: state_next = ST_TI;
      ST_TI:   state_next = ST_RED;
      ST_RED:  state_next = ST_RCL;
      ST_RCL:  state_next = ST_RY;
      ST_RY:   state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/dess_datapath.sv
// Datapath of the de-esser: configuration registers, per-channel filter
// and envelope state, one shared multiplier and the output register. Uses dess_pkg.
module dess_datapath #(
  parameter int NUM_CHANNELS = dess_pkg::NUM_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dess_pkg::dess_cmd_t                 cmd,
  output dess_pkg::dess_status_t              status,
  input  logic                                cfg_we,
  input  logic [dess_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dess_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [dess_pkg::SAMPLE_W-1:0]       sample_in,
  input  logic                                channel_index,
  input  logic                                block_end_in,
  output logic [dess_pkg::SAMPLE_W-1:0]       sample_out,
  output logic                                channel_out,
  output logic                                block_end_out
);
  import dess_pkg::*;

  localparam int CIDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // configuration
  logic signed [COEF_W-1:0] band_b0;
  logic signed [COEF_W-1:0] band_a1;
  logic signed [COEF_W-1:0] band_a2;
  logic        [COEF_W-1:0] attack_coef;
  logic        [COEF_W-1:0] release_coef;
  logic signed [THR_W-1:0]  threshold_level;
  logic        [AMT_W-1:0]  reduction_amount;

  // per-channel state
  logic signed [SAMPLE_W-1:0] input_delay_one [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] input_delay_two [NUM_CHANNELS];
  logic signed [BAND_W-1:0]   band_delay_one  [NUM_CHANNELS];
  logic signed [BAND_W-1:0]   band_delay_two  [NUM_CHANNELS];
  logic        [ENV_W-1:0]    level_envelope  [NUM_CHANNELS];

  // working registers
  logic signed [SAMPLE_W-1:0] x;
  logic                       ch;
  logic                       last;
  logic [CIDX_W-1:0]          cidx;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   acc;
  logic signed [BAND_W-1:0]   y;
  logic        [ENV_W-1:0]    m;
  logic        [ENV_W-1:0]    env;
  logic signed [L2_W-1:0]     l2m;
  logic                       env_zero;
  logic signed [DB_W-1:0]     db;
  logic                       active;
  logic        [16:0]         th;
  logic        [16:0]         r;

  // combinational
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   acc_fin;
  logic signed [PROD_W-1:0]   acc_rnd;
  logic signed [BAND_W-1:0]   y_next;
  logic signed [BAND_W:0]     y_ext;
  logic        [BAND_W:0]     y_abs;
  logic        [ENV_W-1:0]    m_next;
  logic        [ENV_W-1:0]    env_cur;
  logic signed [ENV_W:0]      env_diff;
  logic        [COEF_W-1:0]   coef_sel;
  logic signed [PROD_W-1:0]   e_sum;
  logic        [ENV_W-1:0]    env_next;
  logic        [4:0]          lead;
  logic        [ENV_W-1:0]    frac;
  logic        [ENV_W+LogW-1:0] idx_w;
  logic signed [L2_W-1:0]     l2m_next;
  logic signed [PROD_W-1:0]   rnd16;
  logic signed [PROD_W-1:0]   rnd24;
  logic signed [DB_W:0]       over;
  logic        [19+TanhW:0]   ti_w;
  logic        [16:0]         th_next;
  logic        [16:0]         r_next;
  logic signed [PROD_W-1:0]   o_diff;
  logic        [SAMPLE_W-1:0] o_sat;

  assign cidx           = CIDX_W'(ch);
  assign status.chan_ok = (int'(ch) < NUM_CHANNELS);
  assign env_cur        = level_envelope[cidx];

  // round half up by 16 and by 24 bits
  assign rnd16 = (prod + (PROD_W'(1) <<< 15)) >>> 16;
  assign rnd24 = (prod + (PROD_W'(1) <<< 23)) >>> 24;

  // band output: finish the sum, round, saturate to 32 bits
  assign acc_fin = acc - prod;
  assign acc_rnd = (acc_fin + (PROD_W'(1) <<< 21)) >>> 22;
  always_comb begin
    if (acc_rnd[PROD_W-1] && !(&acc_rnd[PROD_W-2:BAND_W-1])) begin
      y_next = {1'b1, {(BAND_W-1){1'b0}}};
    end else if (!acc_rnd[PROD_W-1] && (|acc_rnd[PROD_W-2:BAND_W-1])) begin
      y_next = {1'b0, {(BAND_W-1){1'b1}}};
    end else begin
      y_next = acc_rnd[BAND_W-1:0];
    end
  end

  // magnitude, saturated to 24 bits
  assign y_ext  = (BAND_W+1)'(y);
  assign y_abs  = y[BAND_W-1] ? (BAND_W+1)'(-y_ext) : (BAND_W+1)'(y_ext);
  assign m_next = (|y_abs[BAND_W:ENV_W]) ? {ENV_W{1'b1}} : y_abs[ENV_W-1:0];

  assign env_diff = $signed({1'b0, env_cur}) - $signed({1'b0, m});
  assign coef_sel = (m > env_cur) ? attack_coef : release_coef;

  // envelope update, clamped to 0..2^24-1
  assign e_sum = rnd24 + $signed(PROD_W'(m));
  always_comb begin
    if (e_sum[PROD_W-1]) begin
      env_next = '0;
    end else if (|e_sum[PROD_W-2:ENV_W]) begin
      env_next = {ENV_W{1'b1}};
    end else begin
      env_next = e_sum[ENV_W-1:0];
    end
  end

  // leading one of the envelope and the log table index below it
  always_comb begin
    lead = '0;
    for (int i = 0; i < ENV_W; i++) begin
      if (env[i]) begin
        lead = 5'(i);
      end
    end
  end
  assign frac     = env & ~(ENV_W'(1) << lead);
  assign idx_w    = {frac, {LogW{1'b0}}} >> lead;
  assign l2m_next = $signed({2'b00, lead, 16'h0000}) - L2_W'(23 * 65536)
                  + $signed({7'b0, LOG_TAB[idx_w[LogW-1:0]]});

  assign over = (DB_W+1)'(db) - (DB_W+1)'(threshold_level);

  // tanh lookup; anything past the table is exactly one
  assign ti_w    = {rnd16[19:0], {TanhW{1'b0}}} >> 11;
  assign th_next = (ti_w >= (20+TanhW)'(TANH_TABLE_DEPTH)) ? ONE_Q16
                 : TANH_TAB[ti_w[TanhW-1:0]];
  assign r_next  = (rnd16 > PROD_W'(65536)) ? ONE_Q16 : rnd16[16:0];

  // output: subtract the scaled band, saturate to 24 bits
  assign o_diff = active ? (PROD_W'(x) - rnd16) : PROD_W'(x);
  always_comb begin
    if (o_diff[PROD_W-1] && !(&o_diff[PROD_W-2:SAMPLE_W-1])) begin
      o_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (!o_diff[PROD_W-1] && (|o_diff[PROD_W-2:SAMPLE_W-1])) begin
      o_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      o_sat = o_diff[SAMPLE_W-1:0];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      ST_B0X: begin
        mul_a = MUL_A_W'(x);
        mul_b = MUL_B_W'(band_b0);
      end
      ST_B0D: begin
        mul_a = MUL_A_W'(input_delay_two[cidx]);
        mul_b = MUL_B_W'(band_b0);
      end
      ST_A1: begin
        mul_a = MUL_A_W'(band_delay_one[cidx]);
        mul_b = MUL_B_W'(band_a1);
      end
      ST_A2: begin
        mul_a = MUL_A_W'(band_delay_two[cidx]);
        mul_b = MUL_B_W'(band_a2);
      end
      ST_ENV: begin
        mul_a = MUL_A_W'(env_diff);
        mul_b = $signed({1'b0, coef_sel});
      end
      ST_DB: begin
        mul_a = MUL_A_W'(l2m);
        mul_b = MUL_B_W'(DB_PER_LOG2_Q16);
      end
      ST_OVER: begin
        mul_a = MUL_A_W'(over);
        mul_b = MUL_B_W'(SCALE_012_Q16);
      end
      ST_RED: begin
        mul_a = $signed(MUL_A_W'(th));
        mul_b = $signed(MUL_B_W'(reduction_amount));
      end
      ST_RY: begin
        mul_a = MUL_A_W'(y);
        mul_b = $signed(MUL_B_W'(r));
      end
      default: ;
    endcase
  end

  // hold the last product while a finished result waits to be loaded
  always_ff @(posedge clk) begin
    if (cmd.step != ST_FIN) begin
      prod <= mul_a * mul_b;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      band_b0          <= '0;
      band_a1          <= '0;
      band_a2          <= '0;
      attack_coef      <= '0;
      release_coef     <= '0;
      threshold_level  <= -16'sd7680;
      reduction_amount <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAND_B0:   band_b0          <= cfg_wdata;
        REG_BAND_A1:   band_a1          <= cfg_wdata;
        REG_BAND_A2:   band_a2          <= cfg_wdata;
        REG_ATTACK:    attack_coef      <= cfg_wdata;
        REG_RELEASE:   release_coef     <= cfg_wdata;
        REG_THRESHOLD: threshold_level  <= cfg_wdata[THR_W-1:0];
        REG_AMOUNT:    reduction_amount <= cfg_wdata[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        input_delay_one[c] <= '0;
        input_delay_two[c] <= '0;
        band_delay_one[c]  <= '0;
        band_delay_two[c]  <= '0;
        level_envelope[c]  <= '0;
      end
    end else begin
      if (cmd.step == ST_ENV) begin
        input_delay_two[cidx] <= input_delay_one[cidx];
        input_delay_one[cidx] <= x;
        band_delay_two[cidx]  <= band_delay_one[cidx];
        band_delay_one[cidx]  <= y;
      end
      if (cmd.step == ST_ENVW) begin
        level_envelope[cidx] <= env_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x      <= sample_in;
      ch     <= channel_index;
      last   <= block_end_in;
      active <= 1'b0;
    end
    unique case (cmd.step)
      ST_B0D:  acc <= prod;
      ST_A1:   acc <= acc - prod;
      ST_A2:   acc <= acc - prod;
      ST_Y:    y   <= y_next;
      ST_M:    m   <= m_next;
      ST_ENVW: env <= env_next;
      ST_LOG: begin
        l2m      <= l2m_next;
        env_zero <= (env == '0);
      end
      ST_CMP:  db <= env_zero ? ZERO_LEVEL_DB : rnd24[DB_W-1:0];
      ST_OVER: active <= (db > DB_W'(threshold_level));
      ST_TI:   th <= th_next;
      ST_RCL:  r  <= r_next;
      default: ;
    endcase
    if (cmd.load_out) begin
      sample_out    <= o_sat;
      channel_out   <= ch;
      block_end_out <= last;
    end
  end

endmodule

// File: src/deesser_sample_processor_core.sv
// De-esser sample processor, top level: ties the sequencer to the datapath.
// Depends on dess_pkg, dess_ctrl and dess_datapath.
//
// Usage:
//  - Input stream: s_tdata carries the signed 24-bit sample, s_tuser the
//    channel (0 left or mono, 1 right), s_tlast the end-of-block mark.
//  - Output stream: m_tdata the de-essed sample, m_tuser and m_tlast
//    copied from the input beat.
//  - Configuration: write cfg_wdata to register cfg_index while cfg_we is
//    high; only while no sample is in flight. Index 0 b0, 1 a1, 2 a2,
//    3 attack, 4 release, 5 threshold, 6 amount.
//  - Sequencing: one multiplier is shared by the nine products of a sample,
//    which the sequencer takes in its order of steps; a new beat is taken
//    only once the sequencer is back in idle after the last sample.
//    A channel beyond NUM_CHANNELS skips the filter steps and passes
//    through unchanged to the output.
//  - s_tready is high only while the sequencer is idle; a finished result
//    waits in the output register, so the next beat is taken meanwhile.
//    If the receiver stalls, the sequencer holds at its last step until
//    the output register frees.
//  - Reset (rst, synchronous) clears filter and envelope state, the
//    registers to their defaults (threshold -30 dB) and the output valid.
module deesser_sample_processor_core #(
  parameter int NUM_CHANNELS = dess_pkg::NUM_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dess_pkg::SAMPLE_W-1:0]     s_tdata,   // [23:0] sample_in
  input  logic                              s_tuser,   // [0] channel_index
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dess_pkg::SAMPLE_W-1:0]     m_tdata,   // [23:0] sample_out
  output logic                              m_tuser,   // [0] channel_out
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [dess_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dess_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dess_pkg::*;

  dess_cmd_t    cmd;
  dess_status_t status;

  // sequencer and handshakes
  dess_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, state and output register
  dess_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .sample_in     (s_tdata),
    .channel_index (s_tuser),
    .block_end_in  (s_tlast),
    .sample_out    (m_tdata),
    .channel_out   (m_tuser),
    .block_end_out (m_tlast)
  );

`ifndef SYNTHESIS
  // a taken beat starts a sample, so ready drops next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in flight");

  // a result appears only from the final step
  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.step) == ST_FIN)
    else $error("output valid raised outside the final step");

  // the output register is loaded only when free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");
`endif

endmodule

// File: verif/dess_checker.sv
// Checker for the de-esser sample processor: watches both stream channels
// and the register port, predicts every output beat and compares fields.
// Depends on dess_pkg for the register indexes and widths.
module dess_checker
  import dess_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [SAMPLE_W-1:0]   m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  end_of_run,
  output int                    fail_count,
  output int                    pending,
  output int                    matched
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FLOOR_DB   = -46080;
  localparam longint UNITY_Q16  = 65536;
  localparam longint DB_PER_OCT = 394566;
  localparam longint EXCESS_K   = 7864;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                chan;
    logic                last;
  } out_beat_t;

  out_beat_t due_q[$];

  longint gain_b0, fb_a1, fb_a2, rise_k, fall_k, thresh, depth;
  longint x_hist1[2], x_hist2[2], y_hist1[2], y_hist2[2], env_lvl[2];
  longint log2_lut[LOG_TABLE_DEPTH];
  longint tanh_lut[TANH_TABLE_DEPTH];
  logic   closed;

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // log2(1 + i/D) by repeated squaring, tanh(8i/D) by series then doubling
  initial begin
    longint unsigned x, r, z, z2, z3, z5, t;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = (longint'(LOG_TABLE_DEPTH + i) << 30) / LOG_TABLE_DEPTH;
      r = 0;
      for (int k = 0; k < 20; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r = r | 64'd1;
          x = x >> 1;
        end
      end
      log2_lut[i] = longint'((r + 8) >> 4);
    end
    for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
      z  = (longint'(i) << 23) / TANH_TABLE_DEPTH;
      z2 = (z * z) >> 30;
      z3 = (z2 * z) >> 30;
      z5 = (z3 * z2) >> 30;
      t  = z - z3 / 3 + (2 * z5) / 15;
      for (int k = 0; k < 10; k++)
        t = ((2 * t) << 30) / ((64'd1 << 30) + ((t * t) >> 30));
      tanh_lut[i] = longint'((t + 8192) >> 14);
    end
  end

  // advance one channel's filter and envelope, return the de-essed sample
  function automatic logic [SAMPLE_W-1:0] deess(longint xs, int c);
    longint acc, y, mag, e, k, lvl, idx, l2, over, ti, th, red, res;
    int     p;
    acc = gain_b0 * xs - gain_b0 * x_hist2[c] - fb_a1 * y_hist1[c] - fb_a2 * y_hist2[c];
    y = clip(round_sh(acc, 22), -64'sd2147483648, 64'sd2147483647);
    x_hist2[c] = x_hist1[c];
    x_hist1[c] = xs;
    y_hist2[c] = y_hist1[c];
    y_hist1[c] = y;
    mag = clip((y < 0) ? -y : y, 0, 24'hFFFFFF);
    e = env_lvl[c];
    k = (mag > e) ? rise_k : fall_k;
    e = clip(mag + round_sh(k * (e - mag), 24), 0, 24'hFFFFFF);
    env_lvl[c] = e;
    if (e == 0) begin
      lvl = FLOOR_DB;
    end else begin
      p = 23;
      while (p > 0 && e[p] == 1'b0) p--;
      idx = ((e - (longint'(1) << p)) * LOG_TABLE_DEPTH) >>> p;
      if (idx >= LOG_TABLE_DEPTH) idx = LOG_TABLE_DEPTH - 1;
      l2  = longint'(p) * 65536 + log2_lut[idx];
      lvl = round_sh((l2 - 23 * 65536) * DB_PER_OCT, 24);
    end
    res = xs;
    if (lvl > thresh) begin
      over = round_sh((lvl - thresh) * EXCESS_K, 16);
      ti   = (over * TANH_TABLE_DEPTH) >>> 11;
      th   = (ti >= TANH_TABLE_DEPTH) ? UNITY_Q16 : tanh_lut[ti];
      red  = round_sh(th * depth, 16);
      if (red > UNITY_Q16) red = UNITY_Q16;
      res = xs - round_sh(red * y, 16);
    end
    res = clip(res, -8388608, 8388607);
    return res[SAMPLE_W-1:0];
  endfunction

  task automatic report(input string what, input longint want, input longint got);
    $display("MISMATCH at %0t: %s expected %0h got %0h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      gain_b0 = 0; fb_a1 = 0; fb_a2 = 0;
      rise_k = 0; fall_k = 0; thresh = -7680; depth = 0;
      for (int c = 0; c < 2; c++) begin
        x_hist1[c] = 0; x_hist2[c] = 0; y_hist1[c] = 0; y_hist2[c] = 0;
        env_lvl[c] = 0;
      end
      due_q.delete();
      fail_count = 0;
      matched    = 0;
      closed     = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BAND_B0:   gain_b0 = longint'($signed(cfg_wdata));
          REG_BAND_A1:   fb_a1   = longint'($signed(cfg_wdata));
          REG_BAND_A2:   fb_a2   = longint'($signed(cfg_wdata));
          REG_ATTACK:    rise_k  = longint'(cfg_wdata);
          REG_RELEASE:   fall_k  = longint'(cfg_wdata);
          REG_THRESHOLD: thresh  = longint'($signed(cfg_wdata[THR_W-1:0]));
          REG_AMOUNT:    depth   = longint'(cfg_wdata[AMT_W-1:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want.chan = s_tuser;
        want.last = s_tlast;
        want.smp  = deess(longint'($signed(s_tdata)), int'(s_tuser));
        due_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (due_q.size() == 0) begin
          report("unexpected beat, sample", 0, m_tdata);
        end else begin
          want = due_q.pop_front();
          if (m_tdata !== want.smp)  report("sample", want.smp, m_tdata);
          if (m_tuser !== want.chan) report("channel", want.chan, m_tuser);
          if (m_tlast !== want.last) report("block end", want.last, m_tlast);
          matched++;
        end
      end
      if (end_of_run && !closed) begin
        closed = 1'b1;
        while (due_q.size() != 0) begin
          want = due_q.pop_front();
          report("missing beat, sample", want.smp, 0);
        end
      end
    end
    pending = due_q.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the de-esser sample processor testbench: clock, reset, stimulus
// and verdict. Depends on dess_pkg, dess_checker and the block itself.
module testbench;
  import dess_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no beat on either side before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 220;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;   // [23:0] sample_in
  logic                  s_tuser = 1'b0; // [0] channel_index
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;        // [23:0] sample_out
  logic                  m_tuser;        // [0] channel_out
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  end_of_run = 1'b0;
  logic                  calm = 1'b0;   // no idling on either side
  int                    fail_count, pending, matched;
  int                    quiet_cycles = 0;
  int                    settings_done = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  deesser_sample_processor_core i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  dess_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_wdata, .end_of_run,
    .fail_count, .pending, .matched
  );

  // Receiver: stall in random bursts, drop stalls once calm.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  // Watchdog: count cycles without any beat moving.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", HANG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat, hold it until taken, then maybe leave a gap.
  task automatic send_beat(input logic [SAMPLE_W-1:0] smp, input logic ch,
                           input logic last);
    s_tdata  <= smp;
    s_tuser  <= ch;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Drain: hold off until every predicted beat has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Write all seven registers on consecutive edges, then drop the enable.
  task automatic load_regs(input logic [CFG_DATA_W-1:0] v [7]);
    logic [CFG_IDX_W-1:0] idx [7];
    idx = '{REG_BAND_B0, REG_BAND_A1, REG_BAND_A2, REG_ATTACK, REG_RELEASE,
            REG_THRESHOLD, REG_AMOUNT};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'(int'($urandom_range(0, 8191)) - 4096);
      3, 4:    return 24'(int'($urandom_range(0, 1048575)) - 524288);
      default: return 24'($urandom());
    endcase
  endfunction

  // Corner beats: zero, both rails, one LSB either side, both channels,
  // both block-end values.
  task automatic corner_beats();
    send_beat(24'h000000, 1'b0, 1'b0);
    send_beat(24'h000000, 1'b1, 1'b0);
    send_beat(24'h7FFFFF, 1'b0, 1'b0);
    send_beat(24'h7FFFFF, 1'b1, 1'b1);
    send_beat(24'h800000, 1'b0, 1'b0);
    send_beat(24'h800000, 1'b1, 1'b0);
    send_beat(24'h000001, 1'b0, 1'b1);
    send_beat(24'hFFFFFF, 1'b1, 1'b1);
    send_beat(24'h7FFFFF, 1'b0, 1'b0);
    send_beat(24'h800000, 1'b0, 1'b1);
  endtask

  // Mostly stereo blocks (left/right pairs, end mark on the last beat);
  // the rest are beats with random channel and end mark.
  task automatic random_beats(input int count);
    int left, pairs;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        pairs = $urandom_range(1, 16);
        for (int p = 0; p < pairs && left > 0; p++) begin
          send_beat(pick_sample(), 1'b0, 1'b0);
          send_beat(pick_sample(), 1'b1, (p == pairs - 1) ? 1'b1 : 1'b0);
          left -= 2;
        end
      end else begin
        send_beat(pick_sample(), 1'($urandom()), 1'($urandom_range(0, 9) == 0));
        left--;
      end
    end
  endtask

  task automatic random_regs(output logic [CFG_DATA_W-1:0] v [7]);
    v[0] = 24'($urandom());
    v[1] = 24'($urandom());
    v[2] = 24'($urandom());
    v[3] = 24'($urandom());
    v[4] = 24'($urandom());
    v[5] = 24'(16'(int'($urandom_range(0, 30720)) - 24576));
    v[6] = 24'($urandom_range(0, 65536));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] regs [7];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: silent side chain, envelope pinned at the floor
    corner_beats();
    drain();

    // ordinary band-pass, slow release, full depth
    regs = '{24'd419430, 24'(-6710886), 24'd3355443, 24'd8388608, 24'd16000000,
             24'(16'(-7680)), 24'd65536};
    load_regs(regs);
    corner_beats();
    random_beats(RANDOM_PER_PHASE);
    drain();

    // instant envelope, lowest threshold: tanh runs off the table
    regs = '{24'd2097152, 24'(-2097152), 24'd1048576, 24'd0, 24'd0,
             24'(16'(-24576)), 24'd65536};
    load_regs(regs);
    random_beats(RANDOM_PER_PHASE);
    drain();

    // negative rails on the filter: band output saturates; highest
    // threshold and zero depth, so the sample passes
    regs = '{24'h800000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
             24'(16'(6144)), 24'd0};
    load_regs(regs);
    random_beats(RANDOM_PER_PHASE);
    drain();

    // zero filter flushes the history; half depth
    regs = '{24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'(16'(-24576)), 24'd32768};
    load_regs(regs);
    random_beats(40);
    drain();

    // positive rails on the filter, threshold at 0 dB
    regs = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd1, 24'd8388608,
             24'd0, 24'd65536};
    load_regs(regs);
    random_beats(RANDOM_PER_PHASE);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      random_regs(regs);
      load_regs(regs);
      if (ph == 2) calm <= 1'b1;
      random_beats(RANDOM_PER_PHASE);
      drain();
    end

    end_of_run <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Covered %0d output beats over %0d register settings,", matched,
             settings_done);
    $display("with corner samples, filter rails and random stalls on both sides.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
